// ===== src/bhws_pkg.sv =====
`default_nettype none
package bhws_pkg;

  // Histogram geometry
  localparam int BIN_COUNT   = 256;
  localparam int BIN_AW      = $clog2(BIN_COUNT);

  // Default counter widths
  localparam int COUNT_BITS_DEF  = 32;
  localparam int LENGTH_BITS_DEF = 16;

  // Output field widths
  localparam int OUT_COUNT_W  = 32;
  localparam int OUT_LENGTH_W = 16;
  localparam int IN_DATA_W    = 16;
  localparam int IN_USER_W    = 2;
  localparam int OUT_DATA_W   = 136;

  // Operation codes carried in tuser
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_END  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUMP = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_byte;   // latch data_byte as bin index, start bin read, extend word
    logic load_read;   // latch bin_index as bin index, start bin read
    logic close_word;  // close the current word
    logic bump;        // write back incremented bin
    logic emit;        // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a new item
  } status_t;

endpackage
`default_nettype wire

// ===== src/bhws_ram.sv =====
`default_nettype none
module bhws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/bhws_ctrl.sv =====
`default_nettype none
module bhws_ctrl
  import bhws_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic [IN_USER_W-1:0] s_tuser,
  output logic                      s_tready,
  input  wire status_t              status,
  output cmd_t                      cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Decode state and incoming item
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(s_tuser))
            OP_BYTE: begin
              cmd.load_byte = 1'b1;
              state_next    = ST_BUMP;
            end
            OP_END: begin
              cmd.close_word = 1'b1;
            end
            OP_READ: begin
              cmd.load_read = 1'b1;
              state_next    = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BUMP: begin
        cmd.bump   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A byte item always goes through the write-back step
  a_byte_bumps: assert property (@(posedge clk) disable iff (rst)
    cmd.load_byte |=> (state == ST_BUMP))
    else $error("byte item did not move to write-back");

  // Never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result loaded while output register busy");

  // Exactly one state bit is set
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");

endmodule
`default_nettype wire

// ===== src/bhws_datapath.sv =====
`default_nettype none
module bhws_datapath
  import bhws_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte, [15:8] bin_index
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int CW = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
  localparam int LW = (LENGTH_BITS > OUT_LENGTH_W) ? LENGTH_BITS : OUT_LENGTH_W;
  localparam int SW = ((COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS) + 1;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;
  localparam logic [OUT_COUNT_W-1:0]  OUT_COUNT_MAX  = '1;
  localparam logic [OUT_LENGTH_W-1:0] OUT_LENGTH_MAX = '1;

  logic [BIN_AW-1:0]      idx;
  logic [BIN_AW-1:0]      rd_addr;
  logic [BIN_COUNT-1:0]   bin_valid;
  logic [COUNT_BITS-1:0]  ram_rdata;
  logic [COUNT_BITS-1:0]  bin_val;
  logic [COUNT_BITS-1:0]  bin_inc;
  logic [LENGTH_BITS-1:0] current_length;
  logic [COUNT_BITS-1:0]  words_seen;
  logic [COUNT_BITS-1:0]  bytes_seen;
  logic [LENGTH_BITS-1:0] length_max;
  logic [LENGTH_BITS-1:0] length_min;
  logic [SW-1:0]          bytes_sum;
  logic                   rd_en;

  logic [CW-1:0]           bin_ext, words_ext, bytes_ext;
  logic [LW-1:0]           max_ext, min_ext;
  logic [OUT_COUNT_W-1:0]  bin_out, words_out, bytes_out;
  logic [OUT_LENGTH_W-1:0] max_out, min_out;

  // Pick the bin address for the read
  assign rd_en   = cmd.load_byte || cmd.load_read;
  assign rd_addr = cmd.load_byte ? s_tdata[BIN_AW-1:0] : s_tdata[8 +: BIN_AW];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      idx <= rd_addr;
    end
  end

  bhws_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_COUNT)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.bump),
    .waddr (idx),
    .wdata (bin_inc),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // A bin never written since reset reads as zero
  assign bin_val = bin_valid[idx] ? ram_rdata : '0;
  assign bin_inc = (bin_val == COUNT_MAX) ? bin_val : bin_val + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (cmd.bump) begin
      bin_valid[idx] <= 1'b1;
    end
  end

  // Word statistics
  assign bytes_sum = SW'(bytes_seen) + SW'(current_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      current_length <= '0;
      words_seen     <= '0;
      bytes_seen     <= '0;
      length_max     <= '0;
      length_min     <= '0;
    end else if (cmd.load_byte) begin
      if (current_length != LENGTH_MAX) begin
        current_length <= current_length + LENGTH_BITS'(1);
      end
    end else if (cmd.close_word) begin
      if (words_seen == '0) begin
        length_max <= current_length;
        length_min <= current_length;
      end else begin
        if (current_length > length_max) begin
          length_max <= current_length;
        end
        if (current_length < length_min) begin
          length_min <= current_length;
        end
      end
      if (words_seen != COUNT_MAX) begin
        words_seen <= words_seen + COUNT_BITS'(1);
      end
      bytes_seen     <= (bytes_sum > SW'(COUNT_MAX)) ? COUNT_MAX : bytes_sum[COUNT_BITS-1:0];
      current_length <= '0;
    end
  end

  // Clamp to output field widths
  assign bin_ext   = CW'(bin_val);
  assign words_ext = CW'(words_seen);
  assign bytes_ext = CW'(bytes_seen);
  assign max_ext   = LW'(length_max);
  assign min_ext   = LW'(length_min);
  assign bin_out   = (bin_ext > CW'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : bin_ext[OUT_COUNT_W-1:0];
  assign words_out = (words_ext > CW'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                      : words_ext[OUT_COUNT_W-1:0];
  assign bytes_out = (bytes_ext > CW'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                      : bytes_ext[OUT_COUNT_W-1:0];
  assign max_out   = (max_ext > LW'(OUT_LENGTH_MAX)) ? OUT_LENGTH_MAX : max_ext[OUT_LENGTH_W-1:0];
  assign min_out   = (min_ext > LW'(OUT_LENGTH_MAX)) ? OUT_LENGTH_MAX : min_ext[OUT_LENGTH_W-1:0];

  // Output register
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {7'd0, (words_seen != '0), min_out, max_out, bytes_out, words_out, bin_out};
    end
  end

  // Written bin becomes valid
  a_bump_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.bump |=> bin_valid[$past(idx)])
    else $error("bin not marked valid after write-back");

  // Closing a word restarts the length
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.close_word |=> (current_length == '0))
    else $error("word length not cleared on close");

  // Shortest never exceeds longest once a word is closed
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (words_seen != '0) |-> (length_min <= length_max))
    else $error("shortest word longer than longest word");

endmodule
`default_nettype wire

// ===== src/byte_histogram_word_stats.sv =====
// Byte item: accepted when idle, then bin read and incremented write-back; no new item
//   is accepted until the write-back step is done.
// End-of-word item: statistics update in the accept cycle.
// Read item: after the registered bin read, the emit step loads the output register and
//   raises m_tvalid once that register is free; no new item is accepted until then. A result
//   still waiting in the output register holds the next read item in the emit step.
// Reset (rst, synchronous, active high) clears all counters and all 256 bin
//   valid flags at once; there is no clearing pass.
`default_nettype none
module byte_histogram_word_stats
  import bhws_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte, [15:8] bin_index
  input  wire logic [IN_USER_W-1:0]  s_tuser,   // [1:0] operation
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // [31:0] bin_count, [63:32] word_total,
                                                // [95:64] symbol_total, [111:96] longest_word,
                                                // [127:112] shortest_word, [128] any_words
);

  cmd_t    cmd;
  status_t status;

  bhws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bhws_datapath #(
    .COUNT_BITS  (COUNT_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
  import bhws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Operation code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycles without any accepted item before the run is declared hung
  localparam int HANG_LIMIT = 1000;
  localparam int LONG_WORD_LEN = 300;
  localparam int RANDOM_ITEMS = 1620;

  // One bin report, laid out as m_tdata[128:0]
  typedef struct packed {
    logic                    any_words;
    logic [OUT_LENGTH_W-1:0] shortest_word;
    logic [OUT_LENGTH_W-1:0] longest_word;
    logic [OUT_COUNT_W-1:0]  symbol_total;
    logic [OUT_COUNT_W-1:0]  word_total;
    logic [OUT_COUNT_W-1:0]  bin_count;
  } bin_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;   // [7:0] data_byte, [15:8] bin_index
  logic [IN_USER_W-1:0]   s_tuser = '0;   // [1:0] operation
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;        // [31:0] bin_count, [63:32] word_total,
                                          // [95:64] symbol_total, [111:96] longest_word,
                                          // [127:112] shortest_word, [128] any_words

  // Shadow copy of the block state
  logic [COUNT_BITS_DEF-1:0]  bin_tally [BIN_COUNT];
  logic [LENGTH_BITS_DEF-1:0] open_len;
  logic [COUNT_BITS_DEF-1:0]  words_closed;
  logic [COUNT_BITS_DEF-1:0]  bytes_closed;
  logic [LENGTH_BITS_DEF-1:0] len_max;
  logic [LENGTH_BITS_DEF-1:0] len_min;

  bin_report_t pending_reports [$];
  int          errors = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_stall_on = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          items_sent = 0;
  logic [7:0]  last_byte = 8'd0;

  byte_histogram_word_stats dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle stretch length: mostly short, a few long
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic clear_model();
    for (int i = 0; i < BIN_COUNT; i++) bin_tally[i] = '0;
    open_len     = '0;
    words_closed = '0;
    bytes_closed = '0;
    len_max      = '0;
    len_min      = '0;
  endtask

  // Advance the shadow state by one accepted item; queue a report for reads
  task automatic tally_item(input logic [1:0] op, input logic [7:0] data_byte,
                            input logic [7:0] bin_index);
    logic [COUNT_BITS_DEF:0] sum;
    bin_report_t             rep;
    case (op)
      OP_BYTE: begin
        if (bin_tally[data_byte] != '1) bin_tally[data_byte] = bin_tally[data_byte] + 1'b1;
        if (open_len != '1) open_len = open_len + 1'b1;
      end
      OP_END: begin
        if (words_closed == '0) begin
          len_max = open_len;
          len_min = open_len;
        end else begin
          if (open_len > len_max) len_max = open_len;
          if (open_len < len_min) len_min = open_len;
        end
        if (words_closed != '1) words_closed = words_closed + 1'b1;
        sum = {1'b0, bytes_closed} + open_len;
        bytes_closed = sum[COUNT_BITS_DEF] ? '1 : sum[COUNT_BITS_DEF-1:0];
        open_len = '0;
      end
      OP_READ: begin
        rep.bin_count     = bin_tally[bin_index];
        rep.word_total    = words_closed;
        rep.symbol_total  = bytes_closed;
        rep.longest_word  = len_max;
        rep.shortest_word = len_min;
        rep.any_words     = (words_closed != '0);
        pending_reports.push_back(rep);
      end
      default: begin
        // unused code: no state change
      end
    endcase
  endtask

  // Drive one item and hold it until accepted; valid stays high for the next caller
  task automatic send_item(input logic [1:0] op, input logic [7:0] data_byte,
                           input logic [7:0] bin_index);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {bin_index, data_byte};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    tally_item(op, data_byte, bin_index);
    if (op != OP_UNUSED) items_sent++;
    if (op == OP_BYTE) last_byte = data_byte;
  endtask

  task automatic send_word(input int len);
    for (int i = 0; i < len; i++)
      send_item(OP_BYTE, 8'($urandom), 8'($urandom));
    send_item(OP_END, 8'($urandom), 8'($urandom));
  endtask

  task automatic read_bin(input logic [7:0] bin_index);
    send_item(OP_READ, 8'($urandom), bin_index);
  endtask

  // Reads before any word is closed: all zero, any_words low
  task automatic test_idle_reads();
    read_bin(8'h00);
    read_bin(8'hFF);
  endtask

  // First word sets both extremes, then a shorter and a longer word move them
  task automatic test_first_word();
    send_item(OP_BYTE, 8'h41, 8'h00);
    send_item(OP_BYTE, 8'h41, 8'hFF);
    send_item(OP_BYTE, 8'h42, 8'h00);
    send_item(OP_END, 8'h00, 8'h00);
    read_bin(8'h41);
    send_item(OP_BYTE, 8'h42, 8'h00);
    send_item(OP_END, 8'hFF, 8'hFF);
    read_bin(8'h42);
    send_word(5);
    read_bin(8'h41);
  endtask

  // Byte values at both ends and around the sign boundary of a char
  task automatic test_byte_extremes();
    send_item(OP_BYTE, 8'h00, 8'h00);
    send_item(OP_BYTE, 8'hFF, 8'h00);
    send_item(OP_BYTE, 8'h80, 8'h00);
    send_item(OP_BYTE, 8'h7F, 8'h00);
    send_item(OP_END, 8'h00, 8'h00);
    read_bin(8'h00);
    read_bin(8'hFF);
    read_bin(8'h80);
    read_bin(8'h7F);
  endtask

  // Unused code: no state change and no report, even in the middle of a word
  task automatic test_ignored_op();
    send_item(OP_BYTE, 8'h33, 8'h00);
    send_item(OP_UNUSED, 8'hFF, 8'hFF);
    send_item(OP_UNUSED, 8'h00, 8'h00);
    read_bin(8'h33);
    send_item(OP_END, 8'h00, 8'h00);
    read_bin(8'hFF);
  endtask

  // Mostly well-formed words with reads in between, plus single random items
  task automatic test_random_text();
    int len;
    while (items_sent < RANDOM_ITEMS) begin
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_item(OP_BYTE, 8'($urandom), 8'($urandom));
          if ($urandom_range(0, 7) == 0) read_bin(last_byte);
        end
        send_item(OP_END, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 1) == 0) read_bin(last_byte);
        if ($urandom_range(0, 2) == 0) read_bin(8'($urandom));
      end else begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end
    end
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  // A word with no bytes still counts and drives the shortest length to zero
  task automatic test_empty_word();
    send_item(OP_END, 8'($urandom), 8'($urandom));
    read_bin(8'($urandom));
    send_item(OP_END, 8'($urandom), 8'($urandom));
    read_bin(last_byte);
  endtask

  // One long word of a single byte value moves the longest length past a byte
  task automatic test_long_word();
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    for (int i = 0; i < LONG_WORD_LEN; i++)
      send_item(OP_BYTE, 8'h5A, 8'($urandom));
    read_bin(8'h5A);
    send_item(OP_END, 8'($urandom), 8'($urandom));
    read_bin(8'h5A);
    rx_stall_on = 1'b1;
    send_word(2);
    read_bin(8'h5A);
  endtask

  // Check each report against the oldest expectation; drive random back-pressure
  always @(posedge clk) begin
    bin_report_t got;
    bin_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(bin_report_t)-1:0];
      if (pending_reports.size() == 0) begin
        $error("unexpected report: %h", got);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got.bin_count !== want.bin_count) begin
          $error("bin_count: expected %0d, actual %0d", want.bin_count, got.bin_count);
          errors++;
        end
        if (got.word_total !== want.word_total) begin
          $error("word_total: expected %0d, actual %0d", want.word_total, got.word_total);
          errors++;
        end
        if (got.symbol_total !== want.symbol_total) begin
          $error("symbol_total: expected %0d, actual %0d", want.symbol_total,
                 got.symbol_total);
          errors++;
        end
        if (got.longest_word !== want.longest_word) begin
          $error("longest_word: expected %0d, actual %0d", want.longest_word,
                 got.longest_word);
          errors++;
        end
        if (got.shortest_word !== want.shortest_word) begin
          $error("shortest_word: expected %0d, actual %0d", want.shortest_word,
                 got.shortest_word);
          errors++;
        end
        if (got.any_words !== want.any_words) begin
          $error("any_words: expected %0d, actual %0d", want.any_words, got.any_words);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left = idle_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Hang detection: count cycles with no item accepted on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_idle_reads();
    test_first_word();
    test_byte_extremes();
    test_ignored_op();
    test_random_text();
    test_empty_word();
    test_long_word();
    s_tvalid <= 1'b0;
    // drain outstanding reports, then let the pipeline settle
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
